FILE: rtl/lookahead_path_tracker_top_assert.svh
// Assertion macros for the lookahead path tracker.
`ifndef LOOKAHEAD_PATH_TRACKER_TOP_ASSERT_SVH
`define LOOKAHEAD_PATH_TRACKER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LPT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpt check failed");
`define LPT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpt check failed");
`else
`define LPT_ASSERT_IMP(lbl, ante, cons)
`define LPT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/lpt_pkg.sv
// Shared types, constants and helpers of the lookahead path tracker.
`timescale 1ns / 1ps
package lpt_pkg;

    localparam int MAX_WAYPOINTS = 256;
    localparam int IDX_W         = $clog2(MAX_WAYPOINTS);
    localparam int CNT_W         = $clog2(MAX_WAYPOINTS + 1);
    localparam int CORDIC_STEPS  = 24;
    localparam logic signed [33:0] CORDIC_KINV = 34'sd163008218;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_STEP   = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        REG_ENABLE    = 3'd0,
        REG_LOOKAHEAD = 3'd1,
        REG_MAX_XY    = 3'd2,
        REG_MAX_Z     = 3'd3,
        REG_YAW_RATE  = 3'd4,
        REG_GAIN_XY   = 3'd5,
        REG_GAIN_Z    = 3'd6
    } reg_index_t;

    typedef enum logic [1:0] {
        PASS_NEAR,
        PASS_AHEAD,
        PASS_TARGET
    } pass_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_SQ,
        ST_CMP,
        ST_SQRT,
        ST_CHK,
        ST_CORDIC,
        ST_MUL,
        ST_ADD,
        ST_DIVX_GO,
        ST_DIVX_WAIT,
        ST_DIVY_GO,
        ST_DIVY_WAIT,
        ST_SCALE,
        ST_EMIT
    } state_t;

    // Divider handshake
    typedef struct packed {
        logic start;
        logic done;
    } div_ctl_t;

    // CORDIC arctangent table, 2^32 per full turn
    function automatic logic signed [33:0] atan_lut(input logic [4:0] i);
        logic signed [33:0] r;
        unique case (i)
            5'd0:  r = 34'sd536870912;
            5'd1:  r = 34'sd316933406;
            5'd2:  r = 34'sd167458907;
            5'd3:  r = 34'sd85004756;
            5'd4:  r = 34'sd42667331;
            5'd5:  r = 34'sd21354465;
            5'd6:  r = 34'sd10679838;
            5'd7:  r = 34'sd5340245;
            5'd8:  r = 34'sd2670163;
            5'd9:  r = 34'sd1335087;
            5'd10: r = 34'sd667544;
            5'd11: r = 34'sd333772;
            5'd12: r = 34'sd166886;
            5'd13: r = 34'sd83443;
            5'd14: r = 34'sd41722;
            5'd15: r = 34'sd20861;
            5'd16: r = 34'sd10430;
            5'd17: r = 34'sd5215;
            5'd18: r = 34'sd2608;
            5'd19: r = 34'sd1304;
            5'd20: r = 34'sd652;
            5'd21: r = 34'sd326;
            5'd22: r = 34'sd163;
            5'd23: r = 34'sd81;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Symmetric clamp to +-lim
    function automatic logic [31:0] clamp_v(input logic signed [64:0] v,
                                            input logic [30:0] lim);
        logic signed [64:0] l;
        logic signed [64:0] nl;
        logic [31:0] r;
        l  = $signed({34'd0, lim});
        nl = -l;
        if (v > l) begin
            r = l[31:0];
        end else if (v < nl) begin
            r = nl[31:0];
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/lookahead_path_tracker_top.sv
// Lookahead path tracker: waypoint memory, scan sequencer and velocity datapath.
// Clear and append complete in the idle state. A control step finds the nearest
// waypoint, scans on from it for the target, takes a square root, runs a CORDIC
// rotation and two serial 64-bit divisions (skipped for a zero range) and emits;
// an empty path goes straight to the emit. Items are taken one at a time. Reset
// empties the path and loads register defaults; no clearing pass.
`timescale 1ns / 1ps
`include "lookahead_path_tracker_top_assert.svh"
module lookahead_path_tracker_top
    import lpt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // pos_x, pos_y, pos_z, heading
    input  logic [1:0]   s_tuser,   // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // vel_x, vel_y, vel_z, yaw_rate
    output logic         m_tuser,   // no_path
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    // Configuration registers
    logic        enable_reg;
    logic [30:0] la_reg, mxy_reg, mz_reg, gxy_reg, gz_reg;
    logic [31:0] yaw_reg;
    logic [61:0] l2_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            enable_reg <= 1'b1;
            la_reg     <= 31'd65536;
            mxy_reg    <= 31'd65536;
            mz_reg     <= 31'd32768;
            yaw_reg    <= 32'hFFFF_B333;
            gxy_reg    <= 31'd65536;
            gz_reg     <= 31'd65536;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ENABLE:    enable_reg <= cfg_data[0];
                REG_LOOKAHEAD: la_reg     <= cfg_data[30:0];
                REG_MAX_XY:    mxy_reg    <= cfg_data[30:0];
                REG_MAX_Z:     mz_reg     <= cfg_data[30:0];
                REG_YAW_RATE:  yaw_reg    <= cfg_data;
                REG_GAIN_XY:   gxy_reg    <= cfg_data[30:0];
                REG_GAIN_Z:    gz_reg     <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Lookahead distance squared, refreshed every cycle
    always_ff @(posedge clk) begin
        l2_reg <= la_reg * la_reg;
    end

    // Control registers
    state_t           state_reg, state_next;
    pass_t            pass_reg, pass_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [5:0]       iter_reg, iter_next;
    logic             out_valid_reg, out_valid_next;

    logic             s_accept;
    action_t          action;
    logic             load_out;
    logic [IDX_W-1:0] last_idx;

    assign s_accept = s_tvalid && s_tready;
    assign action   = action_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));

    // Waypoint memory: {z, y, x}
    logic [95:0] wp_mem [MAX_WAYPOINTS];
    logic [95:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (s_accept && action == ACT_APPEND && count_reg < CNT_W'(MAX_WAYPOINTS)) begin
            wp_mem[count_reg[IDX_W-1:0]] <= s_tdata[95:0];
        end
        rd_data_reg <= wp_mem[idx_reg];
    end

    // Datapath registers
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic signed [15:0] hd_reg;
    logic               empty_reg;
    logic signed [32:0] dx_reg, dy_reg, dz_reg;
    logic [65:0]        sqx_reg, sqy_reg, best_s_reg, s_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [35:0]        rem_reg;
    logic [33:0]        root_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic               flip_reg;
    logic signed [66:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [63:0] xd_reg, yd_reg;
    logic signed [31:0] qx_reg, qy_reg;
    logic signed [63:0] vx_prod_reg, vy_prod_reg;
    logic signed [64:0] vz_prod_reg;

    // Scan arithmetic
    logic signed [32:0] dx_w, dy_w, dz_w;
    logic [32:0]        mx_w, my_w;
    logic [65:0]        s_sum;
    logic               new_best;
    logic [IDX_W-1:0]   best_idx_cur;

    assign dx_w  = $signed({rd_data_reg[31], rd_data_reg[31:0]}) - 33'(px_reg);
    assign dy_w  = $signed({rd_data_reg[63], rd_data_reg[63:32]}) - 33'(py_reg);
    assign dz_w  = $signed({rd_data_reg[95], rd_data_reg[95:64]}) - 33'(pz_reg);
    assign mx_w  = dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
    assign my_w  = dy_w[32] ? 33'(-dy_w) : 33'(dy_w);
    assign s_sum = sqx_reg + sqy_reg;
    assign new_best     = (idx_reg == '0) || (s_sum < best_s_reg);
    assign best_idx_cur = new_best ? idx_reg : best_idx_reg;

    // Square root digit step
    logic [35:0] sq_rem_sh, sq_trial;
    logic        sq_fits;
    assign sq_rem_sh = {rem_reg[33:0], s_reg[65:64]};
    assign sq_trial  = {root_reg, 2'b01};
    assign sq_fits   = sq_rem_sh >= sq_trial;

    // CORDIC step and heading fold
    logic signed [33:0] xs_w, ys_w, at_w;
    logic signed [16:0] h_w, h_adj;
    logic               h_flip;
    logic signed [33:0] c_w, sn_w;
    assign xs_w = cx_reg >>> iter_reg[4:0];
    assign ys_w = cy_reg >>> iter_reg[4:0];
    assign at_w = atan_lut(iter_reg[4:0]);
    assign h_w  = 17'(hd_reg);
    always_comb begin
        h_flip = 1'b0;
        h_adj  = h_w;
        if (h_w > 17'sd16384) begin
            h_adj  = h_w - 17'sd32768;
            h_flip = 1'b1;
        end else if (h_w < -17'sd16384) begin
            h_adj  = h_w + 17'sd32768;
            h_flip = 1'b1;
        end
    end
    assign c_w  = flip_reg ? -cx_reg : cx_reg;
    assign sn_w = flip_reg ? -cy_reg : cy_reg;

    // Divider
    div_ctl_t    div_in, div_out;
    logic [63:0] div_dvd, div_quo;
    logic signed [63:0] div_num;
    logic signed [63:0] q_signed;
    assign div_in.start = (state_reg == ST_DIVX_GO) || (state_reg == ST_DIVY_GO);
    assign div_in.done  = 1'b0;
    assign div_num  = (state_reg == ST_DIVX_GO) ? xd_reg : yd_reg;
    assign div_dvd  = div_num[63] ? 64'(-div_num) : 64'(div_num);
    assign q_signed = ((state_reg == ST_DIVX_WAIT) ? xd_reg[63] : yd_reg[63]) ?
                      -$signed(div_quo) : $signed(div_quo);

    lpt_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (div_in),
        .ctl_out  (div_out),
        .dividend (div_dvd),
        .divisor  (root_reg),
        .quotient (div_quo)
    );

    // Next state and control
    always_comb begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg && !m_tready;
        load_out       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (action)
                        ACT_CLEAR: count_next = '0;
                        ACT_APPEND: begin
                            if (count_reg < CNT_W'(MAX_WAYPOINTS)) begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_STEP: begin
                            if (enable_reg) begin
                                idx_next  = '0;
                                pass_next = PASS_NEAR;
                                state_next = (count_reg == '0) ? ST_EMIT : ST_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD: state_next = ST_SQ;
            ST_SQ: state_next = ST_CMP;
            ST_CMP: begin
                state_next = ST_RD;
                iter_next  = '0;
                unique case (pass_reg)
                    PASS_NEAR: begin
                        if (idx_reg == last_idx) begin
                            pass_next = PASS_AHEAD;
                            idx_next  = best_idx_cur;
                        end else begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                    PASS_AHEAD: begin
                        if ({4'd0, l2_reg} <= s_sum || idx_reg == last_idx) begin
                            pass_next = PASS_TARGET;
                        end else begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                    PASS_TARGET: state_next = ST_SQRT;
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_SQRT: begin
                iter_next = iter_reg + 6'd1;
                if (iter_reg == 6'd32) begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                iter_next  = '0;
                state_next = (root_reg == '0) ? ST_SCALE : ST_CORDIC;
            end
            ST_CORDIC: begin
                iter_next = iter_reg + 6'd1;
                if (iter_reg == 6'(CORDIC_STEPS - 1)) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:       state_next = ST_ADD;
            ST_ADD:       state_next = ST_DIVX_GO;
            ST_DIVX_GO:   state_next = ST_DIVX_WAIT;
            ST_DIVX_WAIT: if (div_out.done) state_next = ST_DIVY_GO;
            ST_DIVY_GO:   state_next = ST_DIVY_WAIT;
            ST_DIVY_WAIT: if (div_out.done) state_next = ST_SCALE;
            ST_SCALE:     state_next = ST_EMIT;
            ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            pass_reg      <= PASS_NEAR;
            idx_reg       <= '0;
            count_reg     <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath
    always_ff @(posedge clk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    px_reg    <= s_tdata[31:0];
                    py_reg    <= s_tdata[63:32];
                    pz_reg    <= s_tdata[95:64];
                    hd_reg    <= s_tdata[111:96];
                    empty_reg <= (count_reg == '0);
                end
            end
            ST_SQ: begin
                dx_reg  <= dx_w;
                dy_reg  <= dy_w;
                dz_reg  <= dz_w;
                sqx_reg <= 66'(mx_w * mx_w);
                sqy_reg <= 66'(my_w * my_w);
            end
            ST_CMP: begin
                if (pass_reg == PASS_NEAR && new_best) begin
                    best_s_reg   <= s_sum;
                    best_idx_reg <= idx_reg;
                end
                s_reg    <= s_sum;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            ST_SQRT: begin
                s_reg    <= {s_reg[63:0], 2'b00};
                rem_reg  <= sq_fits ? 36'(sq_rem_sh - sq_trial) : sq_rem_sh;
                root_reg <= {root_reg[32:0], sq_fits};
            end
            ST_CHK: begin
                cx_reg   <= CORDIC_KINV;
                cy_reg   <= '0;
                cz_reg   <= 34'($signed({h_adj, 16'd0}));
                flip_reg <= h_flip;
                qx_reg   <= '0;
                qy_reg   <= '0;
            end
            ST_CORDIC: begin
                if (!cz_reg[33]) begin
                    cx_reg <= cx_reg - ys_w;
                    cy_reg <= cy_reg + xs_w;
                    cz_reg <= cz_reg - at_w;
                end else begin
                    cx_reg <= cx_reg + ys_w;
                    cy_reg <= cy_reg - xs_w;
                    cz_reg <= cz_reg + at_w;
                end
            end
            ST_MUL: begin
                p1_reg <= dx_reg * c_w;
                p2_reg <= dy_reg * sn_w;
                p3_reg <= dy_reg * c_w;
                p4_reg <= dx_reg * sn_w;
            end
            ST_ADD: begin
                xd_reg <= 64'(p1_reg + p2_reg);
                yd_reg <= 64'(p3_reg - p4_reg);
            end
            ST_DIVX_WAIT: if (div_out.done) qx_reg <= q_signed[31:0];
            ST_DIVY_WAIT: if (div_out.done) qy_reg <= q_signed[31:0];
            ST_SCALE: begin
                vx_prod_reg <= $signed({1'b0, gxy_reg}) * qx_reg;
                vy_prod_reg <= $signed({1'b0, gxy_reg}) * qy_reg;
                vz_prod_reg <= 65'($signed({1'b0, gz_reg}) * dz_reg);
            end
            default: ;
        endcase
    end

    // Output register
    logic [127:0] out_data_reg;
    logic         out_np_reg;
    logic signed [64:0] vx_sh, vy_sh, vz_sh;
    assign vx_sh = $signed({vx_prod_reg[63], vx_prod_reg}) >>> 28;
    assign vy_sh = $signed({vy_prod_reg[63], vy_prod_reg}) >>> 28;
    assign vz_sh = vz_prod_reg >>> 16;

    always_ff @(posedge clk) begin
        if (load_out) begin
            if (empty_reg) begin
                out_data_reg <= '0;
                out_np_reg   <= 1'b1;
            end else begin
                out_data_reg <= {yaw_reg, clamp_v(vz_sh, mz_reg),
                                 clamp_v(vy_sh, mxy_reg), clamp_v(vx_sh, mxy_reg)};
                out_np_reg   <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_np_reg;

    // Checks
    `LPT_ASSERT_IMP(a_no_path_zero, m_tvalid && m_tuser, m_tdata == '0)
    `LPT_ASSERT_NXT(a_clear_empties, s_accept && action == ACT_CLEAR, count_reg == '0)
    `LPT_ASSERT_NXT(a_emit_shows, state_reg == ST_EMIT && !m_tvalid, m_tvalid)

endmodule

FILE: rtl/lpt_divider.sv
// Restoring serial divider, one quotient bit per cycle, unsigned.
`timescale 1ns / 1ps
module lpt_divider
    import lpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  div_ctl_t    ctl_in,
    output div_ctl_t    ctl_out,
    input  logic [63:0] dividend,
    input  logic [33:0] divisor,
    output logic [63:0] quotient
);

    logic [6:0]  cnt_reg;
    logic        done_reg;
    logic [63:0] dvd_reg;
    logic [33:0] rem_reg;
    logic [33:0] dsr_reg;
    logic [63:0] quo_reg;
    logic [34:0] rem_sh;
    logic        fits;

    assign rem_sh = {rem_reg, dvd_reg[63]};
    assign fits   = rem_sh >= {1'b0, dsr_reg};

    // Control: bit counter and done pulse
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (ctl_in.start) begin
                cnt_reg <= 7'd64;
            end else if (cnt_reg != 7'd0) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift, trial subtract
    always_ff @(posedge clk) begin
        if (ctl_in.start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (cnt_reg != 7'd0) begin
            dvd_reg <= {dvd_reg[62:0], 1'b0};
            rem_reg <= fits ? 34'(rem_sh - {1'b0, dsr_reg}) : rem_sh[33:0];
            quo_reg <= {quo_reg[62:0], fits};
        end
    end

    assign ctl_out.start = 1'b0;
    assign ctl_out.done  = done_reg;
    assign quotient      = quo_reg;

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the lookahead path tracker.
`timescale 1ns / 1ps
module testbench;
    import lpt_pkg::*;

    localparam int  WATCHDOG_LIMIT = 20000;
    localparam int  DRAIN_CYCLES   = 2000;
    localparam int  HOLD_CYCLES    = 3000;
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam longint ONE_M = 65536;

    typedef struct packed {
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
        logic [31:0] yaw_rate;
        logic        no_path;
    } vel_cmd_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic         m_tuser;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    lookahead_path_tracker_top dut (.*);

    // Shadow path and registers
    longint      path_x[MAX_WAYPOINTS];
    longint      path_y[MAX_WAYPOINTS];
    longint      path_z[MAX_WAYPOINTS];
    int          path_len;
    logic        en_r;
    logic [30:0] lookahead_r;
    logic [30:0] max_xy_r;
    logic [30:0] max_z_r;
    logic [31:0] yaw_r;
    logic [30:0] gain_xy_r;
    logic [30:0] gain_z_r;

    vel_cmd_t expected_cmds[$];
    int       errors;
    int       idle_cycles;
    bit       sender_idle;
    int       ready_pct;
    bit       hold_request;

    const longint atan_steps[CORDIC_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
    };

    always #1 clk = ~clk;

    function automatic logic [127:0] xy_range_sq(input longint dx, input longint dy);
        logic [127:0] ax;
        logic [127:0] ay;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        return ax * ax + ay * ay;
    endfunction

    function automatic longint root_floor(input logic [127:0] sq);
        logic [127:0] r;
        logic [127:0] t;
        r = 0;
        for (int b = 33; b >= 0; b--)
        begin
            t = r | (128'd1 << b);
            if (t * t <= sq)
                r = t;
        end
        return longint'(r);
    endfunction

    // CORDIC rotation, Q.28 result, folded to within a quarter turn
    task automatic heading_cos_sin(input longint h, output longint c, output longint s);
        bit     flip;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        flip = 0;
        x = 163008218;
        y = 0;
        if (h > 16384)
        begin
            h -= 32768;
            flip = 1;
        end
        else if (h < -16384)
        begin
            h += 32768;
            flip = 1;
        end
        z = h * 65536;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys;
                y += xs;
                z -= atan_steps[i];
            end
            else
            begin
                x += ys;
                y -= xs;
                z += atan_steps[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic logic [31:0] limit_speed(input logic signed [127:0] v,
                                                input logic [30:0] lim);
        logic signed [127:0] l;
        l = $signed({97'd0, lim});
        if (v > l)
            return l[31:0];
        if (v < -l)
            return -l[31:0];
        return v[31:0];
    endfunction

    // Updates the shadow path; returns 1 when a velocity command is due
    task automatic track_item(input logic [1:0] act, input logic [111:0] d,
                              output bit has_cmd, output vel_cmd_t cmd);
        longint px;
        longint py;
        longint pz;
        longint hd;
        longint dx;
        longint dy;
        longint dz;
        longint c;
        longint s;
        longint xy_len;
        logic [127:0] sq;
        logic [127:0] best_sq;
        logic [127:0] la_sq;
        int best;
        int tgt;
        logic signed [127:0] vx;
        logic signed [127:0] vy;
        logic signed [127:0] vz;
        px = $signed(d[31:0]);
        py = $signed(d[63:32]);
        pz = $signed(d[95:64]);
        hd = $signed(d[111:96]);
        has_cmd = 0;
        cmd = '0;
        if (act == ACT_CLEAR)
            path_len = 0;
        else if (act == ACT_APPEND)
        begin
            if (path_len < MAX_WAYPOINTS)
            begin
                path_x[path_len] = px;
                path_y[path_len] = py;
                path_z[path_len] = pz;
                path_len++;
            end
        end
        else if (act == ACT_STEP && en_r)
        begin
            has_cmd = 1;
            if (path_len == 0)
                cmd.no_path = 1;
            else
            begin
                // nearest waypoint, first on ties
                best = 0;
                best_sq = '0;
                for (int i = 0; i < path_len; i++)
                begin
                    sq = xy_range_sq(path_x[i] - px, path_y[i] - py);
                    if (i == 0 || sq < best_sq)
                    begin
                        best_sq = sq;
                        best = i;
                    end
                end
                // first waypoint at or beyond lookahead, else the last one
                la_sq = 128'(lookahead_r) * 128'(lookahead_r);
                tgt = path_len - 1;
                for (int i = best; i < path_len; i++)
                begin
                    if (xy_range_sq(path_x[i] - px, path_y[i] - py) >= la_sq)
                    begin
                        tgt = i;
                        break;
                    end
                end
                dx = path_x[tgt] - px;
                dy = path_y[tgt] - py;
                dz = path_z[tgt] - pz;
                xy_len = root_floor(xy_range_sq(dx, dy));
                vx = 0;
                vy = 0;
                if (xy_len != 0)
                begin
                    heading_cos_sin(hd, c, s);
                    vx = (128'(signed'({1'b0, gain_xy_r})) * ((dx * c + dy * s) / xy_len)) >>> 28;
                    vy = (128'(signed'({1'b0, gain_xy_r})) * ((dy * c - dx * s) / xy_len)) >>> 28;
                end
                vz = (128'(signed'({1'b0, gain_z_r})) * 128'(dz)) >>> 16;
                cmd.vel_x = (xy_len != 0) ? limit_speed(vx, max_xy_r) : '0;
                cmd.vel_y = (xy_len != 0) ? limit_speed(vy, max_xy_r) : '0;
                cmd.vel_z = limit_speed(vz, max_z_r);
                cmd.yaw_rate = yaw_r;
            end
        end
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", field, got, want, $time);
        errors++;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        vel_cmd_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_cmds.size() == 0)
                report_mismatch("unexpected item", m_tdata[31:0], '0);
            else
            begin
                want = expected_cmds.pop_front();
                if (m_tdata[31:0] !== want.vel_x)
                    report_mismatch("vel_x", m_tdata[31:0], want.vel_x);
                if (m_tdata[63:32] !== want.vel_y)
                    report_mismatch("vel_y", m_tdata[63:32], want.vel_y);
                if (m_tdata[95:64] !== want.vel_z)
                    report_mismatch("vel_z", m_tdata[95:64], want.vel_z);
                if (m_tdata[127:96] !== want.yaw_rate)
                    report_mismatch("yaw_rate", m_tdata[127:96], want.yaw_rate);
                if (m_tuser !== want.no_path)
                    report_mismatch("no_path", 32'(m_tuser), 32'(want.no_path));
            end
        end
    end

    // Watchdog on cycles with no accepted item or write
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired at %0t", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: random stalls, and a long hold-off on request
    initial
    begin
        m_tready = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 0;
                m_tready <= 0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_tready <= 1;
            end
            else if ($urandom_range(0, 299) == 0 && ready_pct < 100)
            begin
                m_tready <= 0;
                repeat ($urandom_range(20, 120)) @(posedge clk);
                m_tready <= 1;
            end
            else
                m_tready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    task automatic send_item(input logic [1:0] act, input longint x, input longint y,
                             input longint z, input longint h);
        int gap;
        bit has_cmd;
        vel_cmd_t cmd;
        gap = 0;
        if (sender_idle && $urandom_range(0, 9) >= 6)
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser  <= act;
        s_tdata  <= {h[15:0], z[31:0], y[31:0], x[31:0]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        track_item(act, {h[15:0], z[31:0], y[31:0], x[31:0]}, has_cmd, cmd);
        if (has_cmd)
            expected_cmds.push_back(cmd);
    endtask

    // Waits for the block to go idle, then writes every register
    task automatic set_registers(input logic [31:0] en, input logic [31:0] la,
                                 input logic [31:0] mxy, input logic [31:0] mz,
                                 input logic [31:0] yaw, input logic [31:0] gxy,
                                 input logic [31:0] gz);
        logic [31:0] vals[7];
        vals = '{en, la, mxy, mz, yaw, gxy, gz};
        s_tvalid <= 0;
        wait (expected_cmds.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        for (int i = 0; i < 7; i++)
        begin
            cfg_we    <= 1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            case (reg_index_t'(i))
                REG_ENABLE:    en_r        = vals[i][0];
                REG_LOOKAHEAD: lookahead_r = vals[i][30:0];
                REG_MAX_XY:    max_xy_r    = vals[i][30:0];
                REG_MAX_Z:     max_z_r     = vals[i][30:0];
                REG_YAW_RATE:  yaw_r       = vals[i];
                REG_GAIN_XY:   gain_xy_r   = vals[i][30:0];
                REG_GAIN_Z:    gain_z_r    = vals[i][30:0];
                default: ;
            endcase
        end
        cfg_we <= 0;
    endtask

    function automatic longint near_coord();
        return longint'($urandom_range(0, 20 * 65536)) - 10 * ONE_M;
    endfunction

    function automatic longint any_coord();
        if ($urandom_range(0, 9) == 0)
            return $signed($urandom);
        return near_coord();
    endfunction

    // Extremes and special cases
    task automatic test_directed();
        send_item(ACT_STEP, 0, 0, 0, 0);
        send_item(ACT_APPEND, 0, 0, 0, 0);
        send_item(ACT_STEP, 0, 0, 5 * ONE_M, 0);
        send_item(ACT_STEP, ONE_M, 0, -ONE_M, 16384);
        send_item(ACT_APPEND, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
        send_item(ACT_APPEND, -32'sh80000000, -32'sh80000000, -32'sh80000000, 0);
        send_item(ACT_STEP, -32'sh80000000, 32'h7fffffff, 32'h7fffffff, 32767);
        send_item(ACT_STEP, 32'h7fffffff, -32'sh80000000, -32'sh80000000, -32768);
        send_item(ACT_STEP, 0, 0, 0, 16385);
        send_item(ACT_STEP, 0, 0, 0, -16384);
        send_item(ACT_STEP, 0, 0, 0, -16385);
        send_item(ACT_NONE, 1, 2, 3, 4);
        send_item(ACT_CLEAR, 0, 0, 0, 0);
        send_item(ACT_STEP, 5, 5, 5, 5);
        for (int i = 0; i < 4; i++)
            send_item(ACT_APPEND, i * ONE_M, 0, i * ONE_M, 0);
        send_item(ACT_STEP, 0, ONE_M / 2, 0, 0);
        send_item(ACT_STEP, 2 * ONE_M, 0, 0, 8192);
        send_item(ACT_STEP, 10 * ONE_M, 0, 0, -8192);
        send_item(ACT_STEP, -ONE_M, -ONE_M, 0, 32767);
    endtask

    // A cleared path, a few waypoints, then steps around it; some noise
    task automatic random_burst();
        int n;
        longint bx;
        longint by;
        if ($urandom_range(0, 7) == 0)
        begin
            send_item($urandom_range(0, 3), $signed($urandom), $signed($urandom),
                      $signed($urandom), $urandom_range(0, 65535));
            return;
        end
        send_item(ACT_CLEAR, any_coord(), any_coord(), any_coord(), $urandom_range(0, 65535));
        n = $urandom_range(0, 12);
        bx = near_coord();
        by = near_coord();
        for (int i = 0; i < n; i++)
        begin
            bx += longint'($urandom_range(0, 2 * 65536)) - ONE_M / 2;
            by += longint'($urandom_range(0, 2 * 65536)) - ONE_M;
            if ($urandom_range(0, 9) == 0)
                send_item(ACT_APPEND, any_coord(), any_coord(), $signed($urandom), 0);
            else
                send_item(ACT_APPEND, bx, by, near_coord(), $urandom_range(0, 65535));
        end
        repeat ($urandom_range(1, 5))
            send_item(ACT_STEP, any_coord(), any_coord(), any_coord(), $urandom_range(0, 65535));
    endtask

    // Register sweep with extremes and random settings
    task automatic test_register_sweep();
        set_registers(1, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                      32'h7fffffff, 32'h7fffffff);
        repeat (15) random_burst();
        set_registers(1, 32'hffffffff, 0, 0, 32'h80000000, 0, 0);
        repeat (10) random_burst();
        set_registers(0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        repeat (4) random_burst();
        set_registers(32'hfffffffe | 1, 32'(2 * ONE_M), 32'(3 * ONE_M), 32'(ONE_M), $urandom,
                      32'(2 * ONE_M), 32'(ONE_M / 2));
        repeat (15) random_burst();
    endtask

    // Fill past capacity; the extra appends are dropped
    task automatic test_full_path();
        send_item(ACT_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < MAX_WAYPOINTS + 4; i++)
            send_item(ACT_APPEND, i * ONE_M / 4, (i % 7) * ONE_M / 8, i, 0);
        repeat (3)
            send_item(ACT_STEP, near_coord(), near_coord(), 0, $urandom_range(0, 65535));
        send_item(ACT_STEP, 70 * ONE_M, 0, 0, 0);
        send_item(ACT_CLEAR, 0, 0, 0, 0);
    endtask

    // Receiver holds off while steps keep coming
    task automatic test_backpressure();
        sender_idle = 0;
        send_item(ACT_APPEND, ONE_M, ONE_M, 0, 0);
        hold_request = 1;
        repeat (8)
            send_item(ACT_STEP, near_coord(), near_coord(), near_coord(), $urandom_range(0, 65535));
        sender_idle = 1;
    endtask

    task automatic test_random();
        for (int k = 0; k < 4; k++)
        begin
            ready_pct = (k == 1) ? 100 : $urandom_range(40, 95);
            sender_idle = (k != 1);
            set_registers(1, $urandom_range(0, 6 * 65536), $urandom_range(0, 4 * 65536),
                          $urandom_range(0, 4 * 65536), $urandom,
                          $urandom_range(0, 4 * 65536), $urandom_range(0, 4 * 65536));
            repeat (12) random_burst();
        end
        sender_idle = 1;
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        idle_cycles = 0;
        sender_idle = 1;
        ready_pct = 80;
        hold_request = 0;
        path_len = 0;
        en_r = 1;
        lookahead_r = 65536;
        max_xy_r = 65536;
        max_z_r = 32768;
        yaw_r = -32'sd19661;
        gain_xy_r = 65536;
        gain_z_r = 65536;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        test_directed();
        test_register_sweep();
        test_full_path();
        test_backpressure();
        test_random();

        s_tvalid <= 0;
        wait (expected_cmds.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_cmds.size() != 0)
            report_mismatch("missing item", 32'(expected_cmds.size()), '0);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/lpt_pkg.sv
rtl/lpt_divider.sv
rtl/lookahead_path_tracker_top.sv
dv/testbench.sv
